// ===== design/assert_macros.svh =====
// Assertion helpers; both expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_HOLDS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("property violated");

`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== design/ldq_pkg.sv =====
package ldq_pkg;

  localparam int KIND_W    = 2;
  localparam int CH_W      = 2;
  localparam int LEVEL_W   = 10;
  localparam int DUTY_W    = 10;
  localparam int DELAY_W   = 16;
  localparam int STAMP_W   = 32;

  localparam int DEF_CHANNELS = 4;
  localparam int DEF_DUTY_MAX = 1023;
  localparam int MAX_DRIVE    = 4;
  localparam int LEVEL_MAX    = 1000;

  localparam logic [DELAY_W-1:0] SAVE_DELAY_RST = 16'd1000;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_LEVEL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] OUT_DRIVE    = 2'd0;
  localparam logic [KIND_W-1:0] OUT_SAVE_LVL = 2'd1;
  localparam logic [KIND_W-1:0] OUT_SAVE_PWR = 2'd2;
  localparam logic [KIND_W-1:0] OUT_STATUS   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  out_kind;
    logic [CH_W-1:0]    out_channel;
    logic [DUTY_W-1:0]  duty;
    logic [LEVEL_W-1:0] saved_level;
    logic               power_on;
    logic               last;
  } result_t;

  // elaboration-time integer square root
  function automatic int isqrt(input int x);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= longint'(x)) r++;
    return int'(r);
  endfunction

endpackage

// ===== design/ldq_if.sv =====
interface ldq_evt_if
  import ldq_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [CH_W-1:0]    channel;
  logic [LEVEL_W-1:0] level;
  logic               pressed;

  modport source (output valid, kind, channel, level, pressed, input ready);
  modport sink   (input valid, kind, channel, level, pressed, output ready);
endinterface

interface ldq_res_if
  import ldq_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  out_kind;
  logic [CH_W-1:0]    out_channel;
  logic [DUTY_W-1:0]  duty;
  logic [LEVEL_W-1:0] saved_level;
  logic               power_on;
  logic               last;

  modport source (output valid, out_kind, out_channel, duty, saved_level, power_on, last,
                  input ready);
  modport sink   (input valid, out_kind, out_channel, duty, saved_level, power_on, last,
                  output ready);
endinterface

// ===== design/led_dimmer_quadratic_with_deferred_save_top.sv =====
// LED dimmer with quadratic curve and deferred save. Per-channel duty, level and change
// stamp live in a small synchronous RAM (one entry per channel, valid bits make it read as
// zero after reset, so no clearing pass). One item is worked at a time. A level item
// runs two divisions by constants, each a reciprocal multiply, a remainder and a one-step
// correction, with a squaring step between. A button press reads each channel once, and a
// query reports status only. A tick scans the RAM for due saves, then walks it again to emit
// them and a due power save. Ignored items never leave idle. A result that waits for the
// sink stalls the item in its emitting state. Results leave through an output register, so
// the next item is taken while the last result of the previous one still waits.
module led_dimmer_quadratic_with_deferred_save_top
  import ldq_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int DUTY_MAX = DEF_DUTY_MAX
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DELAY_W-1:0] cfg_wdata_i,
  ldq_evt_if.sink            evt_i,
  ldq_res_if.source          res_o
);

  localparam int NCH    = (CHANNELS > MAX_DRIVE) ? MAX_DRIVE : CHANNELS;
  localparam int IW     = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int ROOT   = isqrt(DUTY_MAX);
  localparam int DIV_K  = LEVEL_MAX + ROOT;
  localparam int DW     = $clog2(DUTY_MAX + 1);
  localparam int KW     = $clog2(DIV_K + 1);
  localparam int QW     = 32;
  localparam int EW     = DW + LEVEL_W + STAMP_W;

  // floor(2^32 / divisor); the estimate is at most one below the quotient
  localparam logic [QW-1:0] RCP_LVL = QW'((64'd1 << QW) / DIV_K);
  localparam logic [QW-1:0] RCP_MAX = QW'((64'd1 << QW) / DUTY_MAX);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_SQ     = 4'd2;
  localparam logic [3:0] S_LVL    = 4'd3;
  localparam logic [3:0] S_DRV_RD = 4'd4;
  localparam logic [3:0] S_DRV    = 4'd5;
  localparam logic [3:0] S_STAT   = 4'd6;
  localparam logic [3:0] S_SCN_RD = 4'd7;
  localparam logic [3:0] S_SCN    = 4'd8;
  localparam logic [3:0] S_SAV_RD = 4'd9;
  localparam logic [3:0] S_SAV    = 4'd10;
  localparam logic [3:0] S_PWR    = 4'd11;
  localparam logic [3:0] S_REM    = 4'd12;
  localparam logic [3:0] S_ADJ    = 4'd13;

  logic [3:0]         state_q, state_d;
  logic               power_q, power_d;
  logic [STAMP_W-1:0] pstamp_q, pstamp_d;
  logic [STAMP_W-1:0] ms_q, ms_d;
  logic [DELAY_W-1:0] delay_q;
  logic [IW-1:0]      idx_q, idx_d;
  logic [LEVEL_W-1:0] lvl_q, lvl_d;
  logic               phase_q, phase_d;
  logic [QW-1:0]      num_q, num_d;
  logic [QW-1:0]      rem_q, rem_d;
  logic [QW-1:0]      quo_q, quo_d;
  logic [NCH-1:0]     due_q, due_d;
  logic [NCH-1:0]     vld_q;
  result_t            res_q, res_d;
  logic               res_vld_q;

  logic [EW-1:0]      mem [NCH];
  logic [EW-1:0]      rdata_q;
  logic               rvld_q;
  logic               mem_we;
  logic [EW-1:0]      mem_wdata;

  logic [EW-1:0]      entry;
  logic [DW-1:0]      e_duty;
  logic [LEVEL_W-1:0] e_lvl;
  logic [STAMP_W-1:0] e_stamp;
  logic               e_due, p_due;
  logic [STAMP_W-1:0] stamp_now;
  logic               accept, out_free, emit, idx_end, later_due;
  logic [KW-1:0]      vv;
  logic [QW-1:0]      rcp, dvs;
  logic [2*QW-1:0]    rprod;
  logic [2*DW-1:0]    sq;
  logic [DW-1:0]      curve;

  assign entry   = rvld_q ? rdata_q : '0;
  assign e_stamp = entry[STAMP_W-1:0];
  assign e_lvl   = entry[STAMP_W +: LEVEL_W];
  assign e_duty  = entry[STAMP_W+LEVEL_W +: DW];

  assign stamp_now = (ms_q == '0) ? '1 : ms_q;
  assign e_due = (e_stamp != '0) && ((ms_q - e_stamp) > STAMP_W'(delay_q));
  assign p_due = (pstamp_q != '0) && ((ms_q - pstamp_q) > STAMP_W'(delay_q));

  assign accept   = evt_i.valid && (state_q == S_IDLE);
  assign out_free = !res_vld_q || res_o.ready;
  assign idx_end  = (idx_q == IW'(NCH - 1));
  assign curve    = quo_q[DW-1:0];

  assign rcp    = phase_q ? RCP_MAX : RCP_LVL;
  assign dvs    = phase_q ? QW'(DUTY_MAX) : QW'(DIV_K);
  assign rprod  = 64'(num_q) * 64'(rcp);
  assign sq     = quo_q[DW-1:0] * quo_q[DW-1:0];
  assign vv     = (evt_i.level == '0) ? '0 : KW'(evt_i.level) + KW'(ROOT);

  always_comb begin
    later_due = 1'b0;
    for (int j = 0; j < NCH; j++) begin
      if ((IW'(j) > idx_q) && due_q[j]) later_due = 1'b1;
    end
  end

  always_comb begin
    state_d   = state_q;
    power_d   = power_q;
    pstamp_d  = pstamp_q;
    ms_d      = ms_q;
    idx_d     = idx_q;
    lvl_d     = lvl_q;
    phase_d   = phase_q;
    num_d     = num_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    due_d     = due_q;
    emit      = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_wdata = entry;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (evt_i.kind)
            KIND_LEVEL: begin
              if ((evt_i.level <= LEVEL_W'(LEVEL_MAX)) && (int'(evt_i.channel) < NCH)) begin
                idx_d   = evt_i.channel[IW-1:0];
                lvl_d   = evt_i.level;
                num_d   = QW'(DUTY_MAX) * QW'(vv);
                phase_d = 1'b0;
                state_d = S_MUL;
              end
            end
            KIND_BUTTON: begin
              if (evt_i.pressed) begin
                power_d  = !power_q;
                pstamp_d = stamp_now;
                idx_d    = '0;
                state_d  = S_DRV_RD;
              end else begin
                state_d = S_STAT;
              end
            end
            KIND_TICK: begin
              ms_d    = ms_q + 1'b1;
              idx_d   = '0;
              state_d = S_SCN_RD;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        quo_d   = rprod[2*QW-1:QW];
        state_d = S_REM;
      end
      S_REM: begin
        rem_d   = num_q - (quo_q * dvs);
        state_d = S_ADJ;
      end
      S_ADJ: begin
        if (rem_q >= dvs) quo_d = quo_q + 1'b1;
        state_d = phase_q ? S_LVL : S_SQ;
      end
      S_SQ: begin
        num_d   = QW'(sq);
        phase_d = 1'b1;
        state_d = S_MUL;
      end
      S_LVL: begin
        if (!power_q || out_free) begin
          if (curve != e_duty) begin
            mem_we    = 1'b1;
            mem_wdata = {curve, lvl_q, stamp_now};
          end
          if (power_q) begin
            emit  = 1'b1;
            res_d = '{out_kind: OUT_DRIVE, out_channel: CH_W'(idx_q),
                      duty: DUTY_W'(curve), saved_level: '0,
                      power_on: power_q, last: 1'b1};
          end
          state_d = S_IDLE;
        end
      end
      S_DRV_RD: state_d = S_DRV;
      S_DRV: begin
        if (out_free) begin
          emit  = 1'b1;
          res_d = '{out_kind: OUT_DRIVE, out_channel: CH_W'(idx_q),
                    duty: power_q ? DUTY_W'(e_duty) : '0, saved_level: '0,
                    power_on: power_q, last: 1'b0};
          if (idx_end) begin
            state_d = S_STAT;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_DRV_RD;
          end
        end
      end
      S_STAT: begin
        if (out_free) begin
          emit    = 1'b1;
          res_d   = '{out_kind: OUT_STATUS, out_channel: '0, duty: '0, saved_level: '0,
                      power_on: power_q, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_SCN_RD: state_d = S_SCN;
      S_SCN: begin
        due_d[idx_q] = e_due;
        if (idx_end) begin
          idx_d   = '0;
          state_d = S_SAV_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SCN_RD;
        end
      end
      S_SAV_RD: state_d = S_SAV;
      S_SAV: begin
        if (!due_q[idx_q] || out_free) begin
          if (due_q[idx_q]) begin
            emit      = 1'b1;
            res_d     = '{out_kind: OUT_SAVE_LVL, out_channel: CH_W'(idx_q), duty: '0,
                          saved_level: e_lvl, power_on: power_q,
                          last: !later_due && !p_due};
            mem_we    = 1'b1;
            mem_wdata = {e_duty, e_lvl, STAMP_W'(0)};
          end
          if (idx_end) begin
            state_d = S_PWR;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_SAV_RD;
          end
        end
      end
      S_PWR: begin
        if (!p_due) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          emit     = 1'b1;
          res_d    = '{out_kind: OUT_SAVE_PWR, out_channel: '0, duty: '0, saved_level: '0,
                       power_on: power_q, last: 1'b1};
          pstamp_d = '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      power_q   <= 1'b1;
      pstamp_q  <= '0;
      ms_q      <= '0;
      delay_q   <= SAVE_DELAY_RST;
      vld_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      power_q  <= power_d;
      pstamp_q <= pstamp_d;
      ms_q     <= ms_d;
      if (cfg_we_i) delay_q <= cfg_wdata_i;
      if (mem_we) vld_q[idx_q] <= 1'b1;
      if (emit) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    lvl_q   <= lvl_d;
    phase_q <= phase_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    due_q   <= due_d;
    if (emit) res_q <= res_d;
  end

  // channel RAM, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[idx_q] <= mem_wdata;
    rdata_q <= mem[idx_q];
    rvld_q  <= vld_q[idx_q];
  end

  assign evt_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = res_vld_q;
  assign res_o.out_kind    = res_q.out_kind;
  assign res_o.out_channel = res_q.out_channel;
  assign res_o.duty        = res_q.duty;
  assign res_o.saved_level = res_q.saved_level;
  assign res_o.power_on    = res_q.power_on;
  assign res_o.last        = res_q.last;

endmodule

// ===== design/ldq_checker.sv =====
`include "assert_macros.svh"

module ldq_checker
  import ldq_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               evt_valid_i,
  input logic               evt_ready_i,
  input logic [KIND_W-1:0]  evt_kind_i,
  input logic [LEVEL_W-1:0] evt_level_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic [KIND_W-1:0]  res_kind_i,
  input logic [CH_W-1:0]    res_channel_i,
  input logic [DUTY_W-1:0]  res_duty_i,
  input logic [LEVEL_W-1:0] res_level_i,
  input logic               res_power_i,
  input logic               res_last_i
);

  logic evt_xfer, res_xfer, ignored;
  logic [$bits(result_t)-1:0] res_bits;

  assign evt_xfer = evt_valid_i && evt_ready_i;
  assign res_xfer = res_valid_i && res_ready_i;
  assign res_bits = {res_kind_i, res_channel_i, res_duty_i, res_level_i, res_power_i,
                     res_last_i};
  assign ignored  = (evt_kind_i == KIND_UNUSED) ||
                    ((evt_kind_i == KIND_LEVEL) && (evt_level_i > LEVEL_W'(LEVEL_MAX)));

  `ASSERT_HOLDS(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_bits))
  `ASSERT_NEVER(a_accept_mid_item, evt_xfer && res_valid_i && !res_last_i)
  `ASSERT_HOLDS(a_ignored_fast, evt_xfer && ignored |=> evt_ready_i)
  `ASSERT_NEVER(a_off_drive_dark, res_valid_i && res_kind_i == OUT_DRIVE && !res_power_i && res_duty_i != '0)
  `ASSERT_HOLDS(a_status_last, res_xfer && res_kind_i == OUT_STATUS |-> res_last_i)

endmodule

bind led_dimmer_quadratic_with_deferred_save_top ldq_checker u_ldq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .evt_valid_i   (evt_i.valid),
  .evt_ready_i   (evt_i.ready),
  .evt_kind_i    (evt_i.kind),
  .evt_level_i   (evt_i.level),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_kind_i    (res_o.out_kind),
  .res_channel_i (res_o.out_channel),
  .res_duty_i    (res_o.duty),
  .res_level_i   (res_o.saved_level),
  .res_power_i   (res_o.power_on),
  .res_last_i    (res_o.last)
);

// ===== bench/led_dimmer_quadratic_with_deferred_save_top_tb.sv =====
module led_dimmer_quadratic_with_deferred_save_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ldq_pkg::*;

  localparam int CURVE_ROOT    = 31;  // floor(sqrt(DEF_DUTY_MAX))
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DIR_ROWS      = 21;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CH_W-1:0]    channel;
    logic [LEVEL_W-1:0] level;
    logic               pressed;
  } dimmer_evt_t;

  localparam int EVT_W = $bits(dimmer_evt_t);

  typedef struct packed {
    dimmer_evt_t evt;
    logic        typed;
    logic        has_res;
    result_t     res;
  } dir_row_t;

  localparam result_t NO_CMD = '0;

  // typed rows carry their own result; the others take theirs from dimmer_react
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{KIND_LEVEL, 2'd0, 10'd1000, 1'b0}, 1'b1, 1'b1,
      '{OUT_DRIVE, 2'd0, 10'd1023, 10'd0, 1'b1, 1'b1}},
    '{'{KIND_LEVEL, 2'd1, 10'd0, 1'b0}, 1'b1, 1'b1,
      '{OUT_DRIVE, 2'd1, 10'd0, 10'd0, 1'b1, 1'b1}},
    '{'{KIND_LEVEL, 2'd2, 10'd1001, 1'b0}, 1'b1, 1'b0, NO_CMD},
    '{'{KIND_LEVEL, 2'd3, 10'd1023, 1'b1}, 1'b1, 1'b0, NO_CMD},
    '{'{KIND_UNUSED, 2'd3, 10'd1023, 1'b1}, 1'b1, 1'b0, NO_CMD},
    '{'{KIND_BUTTON, 2'd0, 10'd0, 1'b0}, 1'b1, 1'b1,
      '{OUT_STATUS, 2'd0, 10'd0, 10'd0, 1'b1, 1'b1}},
    '{'{KIND_TICK, 2'd0, 10'd0, 1'b0}, 1'b0, 1'b0, NO_CMD},
    '{'{KIND_LEVEL, 2'd3, 10'd1, 1'b0}, 1'b0, 1'b0, NO_CMD},
    '{'{KIND_LEVEL, 2'd2, 10'd500, 1'b0}, 1'b0, 1'b0, NO_CMD},
    '{'{KIND_LEVEL, 2'd1, 10'd999, 1'b0}, 1'b0, 1'b0, NO_CMD},
    '{'{KIND_BUTTON, 2'd0, 10'd0, 1'b1}, 1'b0, 1'b0, NO_CMD},
    '{'{KIND_LEVEL, 2'd0, 10'd250, 1'b0}, 1'b1, 1'b0, NO_CMD},
    '{'{KIND_BUTTON, 2'd0, 10'd0, 1'b0}, 1'b1, 1'b1,
      '{OUT_STATUS, 2'd0, 10'd0, 10'd0, 1'b0, 1'b1}},
    '{'{KIND_TICK, 2'd0, 10'd0, 1'b0}, 1'b0, 1'b0, NO_CMD},
    '{'{KIND_TICK, 2'd0, 10'd0, 1'b0}, 1'b0, 1'b0, NO_CMD},
    '{'{KIND_BUTTON, 2'd0, 10'd0, 1'b1}, 1'b0, 1'b0, NO_CMD},
    '{'{KIND_LEVEL, 2'd0, 10'd0, 1'b0}, 1'b0, 1'b0, NO_CMD},
    '{'{KIND_LEVEL, 2'd3, 10'd1000, 1'b0}, 1'b0, 1'b0, NO_CMD},
    '{'{KIND_TICK, 2'd0, 10'd0, 1'b0}, 1'b0, 1'b0, NO_CMD},
    '{'{KIND_BUTTON, 2'd3, 10'd1023, 1'b0}, 1'b0, 1'b0, NO_CMD},
    '{'{KIND_TICK, 2'd3, 10'd1023, 1'b1}, 1'b0, 1'b0, NO_CMD}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [DELAY_W-1:0] cfg_wdata_i;

  ldq_evt_if evt_if ();
  ldq_res_if res_if ();

  led_dimmer_quadratic_with_deferred_save_top i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .evt_i (evt_if),
    .res_o (res_if)
  );

  // dimmer state as the block should hold it
  logic                pwr_on     = 1'b1;
  logic [DUTY_W-1:0]   chan_duty  [MAX_DRIVE] = '{default: '0};
  logic [LEVEL_W-1:0]  chan_level [MAX_DRIVE] = '{default: '0};
  logic [STAMP_W-1:0]  chan_stamp [MAX_DRIVE] = '{default: '0};
  logic [STAMP_W-1:0]  pwr_stamp  = '0;
  logic [STAMP_W-1:0]  ms_now     = '0;
  logic [DELAY_W-1:0]  save_delay = SAVE_DELAY_RST;

  result_t led_cmds_due [$];
  int      fail_cnt  = 0;
  int      cycle_cnt = 0;
  int      idle_pct  = 20;
  bit      calm      = 1'b0;
  bit      no_gap    = 1'b0;
  logic    hold_req  = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [DUTY_W-1:0] quad_duty(input logic [LEVEL_W-1:0] lvl);
    longint unsigned vv;
    longint unsigned d;
    vv = (lvl != 0) ? longint'(lvl) + CURVE_ROOT : 0;
    d  = (DEF_DUTY_MAX * vv) / (LEVEL_MAX + CURVE_ROOT);
    d  = (d * d) / DEF_DUTY_MAX;
    return d[DUTY_W-1:0];
  endfunction

  function automatic logic [STAMP_W-1:0] stamp_now();
    return (ms_now != 0) ? ms_now : '1;
  endfunction

  function automatic result_t led_cmd(input logic [KIND_W-1:0] k, input logic [CH_W-1:0] ch,
                                      input logic [DUTY_W-1:0] d,
                                      input logic [LEVEL_W-1:0] lv);
    return '{k, ch, d, lv, pwr_on, 1'b0};
  endfunction

  task automatic dimmer_react(input dimmer_evt_t e, output result_t cmds [$]);
    logic [DUTY_W-1:0]  d;
    logic [STAMP_W-1:0] age;
    cmds = {};
    case (e.kind)
      KIND_LEVEL: begin
        if (e.level <= LEVEL_MAX) begin
          d = quad_duty(e.level);
          if (d != chan_duty[e.channel]) begin
            chan_stamp[e.channel] = stamp_now();
            chan_duty[e.channel]  = d;
            chan_level[e.channel] = e.level;
          end
          if (pwr_on) cmds.push_back(led_cmd(OUT_DRIVE, e.channel, chan_duty[e.channel], '0));
        end
      end
      KIND_BUTTON: begin
        if (e.pressed) begin
          pwr_on    = ~pwr_on;
          pwr_stamp = stamp_now();
          for (int i = 0; i < MAX_DRIVE; i++)
            cmds.push_back(led_cmd(OUT_DRIVE, CH_W'(i), pwr_on ? chan_duty[i] : '0, '0));
        end
        cmds.push_back(led_cmd(OUT_STATUS, '0, '0, '0));
      end
      KIND_TICK: begin
        ms_now = ms_now + 1;
        for (int i = 0; i < MAX_DRIVE; i++) begin
          age = ms_now - chan_stamp[i];
          if (chan_stamp[i] != 0 && age > save_delay) begin
            cmds.push_back(led_cmd(OUT_SAVE_LVL, CH_W'(i), '0, chan_level[i]));
            chan_stamp[i] = '0;
          end
        end
        age = ms_now - pwr_stamp;
        if (pwr_stamp != 0 && age > save_delay) begin
          cmds.push_back(led_cmd(OUT_SAVE_PWR, '0, '0, '0));
          pwr_stamp = '0;
        end
      end
      default: ;
    endcase
    if (cmds.size() != 0) cmds[cmds.size()-1].last = 1'b1;
  endtask

  function automatic dimmer_evt_t rand_evt();
    dimmer_evt_t e;
    int unsigned sel;
    e   = EVT_W'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 38) begin
      e.kind = KIND_LEVEL;
      sel = $urandom_range(0, 19);
      if (sel == 0) e.level = '0;
      else if (sel == 1) e.level = LEVEL_W'(LEVEL_MAX);
      else if (sel == 2) e.level = LEVEL_W'($urandom_range(LEVEL_MAX + 1, 1023));
      else e.level = LEVEL_W'($urandom_range(0, LEVEL_MAX));
    end else if (sel < 60) begin
      e.kind    = KIND_BUTTON;
      e.pressed = ($urandom_range(0, 3) != 0);
    end else if (sel < 96) begin
      e.kind = KIND_TICK;
    end else begin
      e.kind = KIND_UNUSED;
    end
    return e;
  endfunction

  // returns at the edge where the transfer happens; valid stays high
  task automatic send_evt(input dimmer_evt_t e);
    if (!calm && !no_gap && $urandom_range(0, 99) < idle_pct) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    evt_if.valid   <= 1'b1;
    evt_if.kind    <= e.kind;
    evt_if.channel <= e.channel;
    evt_if.level   <= e.level;
    evt_if.pressed <= e.pressed;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
  endtask

  task automatic send_and_predict(input dimmer_evt_t e);
    result_t cmds [$];
    send_evt(e);
    dimmer_react(e, cmds);
    foreach (cmds[k]) led_cmds_due.push_back(cmds[k]);
  endtask

  task automatic random_items(input int count);
    dimmer_evt_t e;
    int done;
    done = 0;
    while (done < count) begin
      e = rand_evt();
      send_and_predict(e);
      if (!(e.kind == KIND_UNUSED || (e.kind == KIND_LEVEL && e.level > LEVEL_MAX)))
        done++;
    end
  endtask

  task automatic drain(input int extra);
    evt_if.valid <= 1'b0;
    do @(posedge clk_i); while (led_cmds_due.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_delay(input logic [DELAY_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    save_delay  = val;
  endtask

  initial begin
    evt_if.valid   <= 1'b0;
    evt_if.kind    <= '0;
    evt_if.channel <= '0;
    evt_if.level   <= '0;
    evt_if.pressed <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    rst_ni         <= 1'b0;
  end

  // sink side: random stalls, one long hold-off on request
  initial begin : res_ready_gen
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        hold_req     <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic int field_bad(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin : cmd_check
    result_t want;
    int      n_bad;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (led_cmds_due.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got kind %0d ch %0d duty %0d",
                 $time, res_if.out_kind, res_if.out_channel, res_if.duty);
        fail_cnt++;
      end else begin
        want  = led_cmds_due.pop_front();
        n_bad = field_bad("out_kind", 32'(want.out_kind), 32'(res_if.out_kind))
              + field_bad("out_channel", 32'(want.out_channel), 32'(res_if.out_channel))
              + field_bad("duty", 32'(want.duty), 32'(res_if.duty))
              + field_bad("saved_level", 32'(want.saved_level), 32'(res_if.saved_level))
              + field_bad("power_on", 32'(want.power_on), 32'(res_if.power_on))
              + field_bad("last", 32'(want.last), 32'(res_if.last));
        if (n_bad != 0) fail_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d transfers still due", $time, led_cmds_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : main_seq
    result_t     cmds [$];
    dimmer_evt_t e;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // zero delay first so the all-ones stamp from clock 0 saves on the next tick
    write_delay('0);
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_evt(DIR_TAB[r].evt);
      dimmer_react(DIR_TAB[r].evt, cmds);
      if (!DIR_TAB[r].typed) begin
        foreach (cmds[k]) led_cmds_due.push_back(cmds[k]);
      end else if (DIR_TAB[r].has_res) begin
        led_cmds_due.push_back(DIR_TAB[r].res);
      end
    end

    drain(SETTLE_CYCLES);
    write_delay(16'd2);
    idle_pct = 25;
    random_items(80);

    // max delay; stall the sink long enough for the block to back up
    drain(SETTLE_CYCLES);
    write_delay('1);
    hold_req <= 1'b1;
    no_gap    = 1'b1;
    repeat (24) begin
      e      = rand_evt();
      e.kind = KIND_BUTTON;
      send_and_predict(e);
    end
    no_gap = 1'b0;
    drain(0);
    random_items(50);

    drain(SETTLE_CYCLES);
    write_delay(16'd1);
    idle_pct = 40;
    random_items(70);

    drain(SETTLE_CYCLES);
    write_delay(16'd12);
    idle_pct = 10;
    random_items(70);

    drain(SETTLE_CYCLES);
    write_delay(16'd5);
    calm = 1'b1;
    random_items(70);

    drain(SETTLE_CYCLES);
    if (fail_cnt == 0 && led_cmds_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
